[hdl/gmv_pkg.sv]
// gmv_pkg: widths, register indexes, sequencer states and divider status
// for the group mean and variance core. No dependencies.
`default_nettype none

package gmv_pkg;

    // field and register widths
    localparam int SAMPLE_W  = 16;
    localparam int LEN_W     = 13;
    localparam int CNT_W     = 16;
    localparam int CFG_W     = 16;
    localparam int MEAN_W    = 24;
    localparam int VAR_W     = 39;
    localparam int FRAC_BITS = 8;

    // accumulators, sized for the largest group
    localparam int MAX_GROUP_LENGTH = 4096;
    localparam int SUM_W   = 28;
    localparam int SQSUM_W = 43;

    // shared multiplier operand width and the square of the quotient
    localparam int MUL_W = 18;
    localparam int PROD_W = 2 * MUL_W;
    localparam int QUO_W  = 2 * MUL_W;
    localparam int MSQ_ACC_W = 64;
    localparam int MSQ_W  = MSQ_ACC_W - FRAC_BITS;

    // divider
    localparam int DIVD_W     = SQSUM_W + FRAC_BITS;
    localparam int DIV_STEP_W = $clog2(DIVD_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT  = 1'b1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_MSTART,
        S_MDIV,
        S_P0,
        S_P1,
        S_P2,
        S_VSTART,
        S_VDIV,
        S_OUT
    } state_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[hdl/gmv_divider.sv]
// gmv_divider: restoring divider, one quotient bit per cycle, shared by the
// mean and mean-square divisions. Depends on gmv_pkg.
`default_nettype none

module gmv_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [gmv_pkg::DIVD_W-1:0] dividend,
    input  wire logic [gmv_pkg::LEN_W-1:0]  divisor,
    output logic      [gmv_pkg::DIVD_W-1:0] quotient,
    output gmv_pkg::div_stat_t              stat
);
    import gmv_pkg::*;

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIVD_W - 1);

    logic [DIVD_W-1:0]     work_reg;
    logic [LEN_W-1:0]      rem_reg;
    logic [LEN_W-1:0]      dsr_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [LEN_W+1:0]      trial;
    logic                  borrow;

    // trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        trial  = {1'b0, rem_reg, work_reg[DIVD_W-1]} - {2'b00, dsr_reg};
        borrow = trial[LEN_W+1];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // done pulses for one cycle after the final step
            done_reg <= !start && run_reg && (step_reg == LAST_STEP);
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    run_reg <= 1'b0;
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end
        else if (run_reg)
        begin
            work_reg <= {work_reg[DIVD_W-2:0], ~borrow};
            if (borrow)
                rem_reg <= {rem_reg[LEN_W-2:0], work_reg[DIVD_W-1]};
            else
                rem_reg <= trial[LEN_W-1:0];
        end
    end

    assign quotient  = work_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

`ifndef SYNTHESIS
    // a new division never starts on top of a running one
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider started while busy");

    // done follows the final step of a run
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg) && !run_reg)
        else $error("divider done without a finished run");

    // step counter stays inside the dividend
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> step_reg <= LAST_STEP)
        else $error("divider step out of range");
`endif

endmodule

`default_nettype wire

[hdl/group_mean_variance_core.sv]
// group_mean_variance_core: per-group mean and population variance in Q8,
// one shared multiplier and one shared divider under a sequencer.
// Depends on gmv_pkg and gmv_divider.
//
//   channel   direction  signals                                    handshake
//   input     in         sample                                     in_valid / in_ready
//   result    out        mean_q8, variance_q8, last_group           out_valid / out_ready
//   config    in         cfg_index, cfg_data                        cfg_write
//
// a sample that does not close its group is accepted, then accumulated
// a group-closing sample also runs two 51-step divisions in the shared
// divider, plus 3 partial products for the mean square
// the result sits in an output register; the next group's samples are taken
// while it waits, and only the closing step of a later group stalls on it
// asynchronous reset clears accumulators and counters, no clearing pass
`default_nettype none

module group_mean_variance_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [gmv_pkg::SAMPLE_W-1:0] sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [gmv_pkg::MEAN_W-1:0]  mean_q8,
    output logic        [gmv_pkg::VAR_W-1:0]   variance_q8,
    output logic                               last_group,
    input  wire logic                          cfg_write,
    input  wire logic [gmv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gmv_pkg::CFG_W-1:0]     cfg_data
);
    import gmv_pkg::*;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_GROUP_LENGTH);
    localparam int HALF_W = QUO_W / 2;

    state_t state_reg, state_next;

    // configuration
    logic [LEN_W-1:0] group_length_reg;
    logic [CNT_W-1:0] group_count_reg;

    // accumulation state
    logic signed [SUM_W-1:0] running_sum_reg;
    logic [SQSUM_W-1:0]      running_square_sum_reg;
    logic [LEN_W-1:0]        samples_in_group_reg;
    logic [CNT_W-1:0]        groups_done_reg;

    // per-item and per-group working registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [QUO_W-1:0]           q_reg;
    logic [MSQ_ACC_W-1:0]       msq_acc_reg;

    // output register
    logic                     out_valid_reg;
    logic signed [MEAN_W-1:0] mean_reg;
    logic [VAR_W-1:0]         var_reg;
    logic                     last_reg;

    // combinational values
    logic [LEN_W-1:0]    eff_len;
    logic [CNT_W-1:0]    eff_cnt;
    logic [SAMPLE_W-1:0] xmag;
    logic [LEN_W-1:0]    cnt_inc;
    logic                sneg;
    logic [SUM_W-1:0]    smag;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [PROD_W-1:0]   prod;
    logic [DIVD_W-1:0]   div_dividend;
    logic [DIVD_W-1:0]   div_quotient;
    logic                div_start;
    div_stat_t           div_stat;
    logic [MSQ_W-1:0]    msq;
    logic [MSQ_W-1:0]    ex2_ext;
    logic [MSQ_W-1:0]    var_full;
    logic [CNT_W-1:0]    groups_inc;
    logic                group_last;
    logic                out_free;
    logic                in_take;

    // effective length and count: zero means one, length saturates
    always_comb
    begin
        if (group_length_reg == '0)
            eff_len = LEN_W'(1);
        else if (group_length_reg > LEN_MAX)
            eff_len = LEN_MAX;
        else
            eff_len = group_length_reg;
        eff_cnt = (group_count_reg == '0) ? CNT_W'(1) : group_count_reg;
    end

    // magnitudes and counter increments
    always_comb
    begin
        xmag       = sample_reg[SAMPLE_W-1] ? SAMPLE_W'(-sample_reg) : sample_reg;
        cnt_inc    = samples_in_group_reg + 1'b1;
        sneg       = running_sum_reg[SUM_W-1];
        smag       = sneg ? SUM_W'(-running_sum_reg) : running_sum_reg;
        groups_inc = groups_done_reg + 1'b1;
        group_last = groups_inc >= eff_cnt;
        out_free   = !out_valid_reg || out_ready;
        in_take    = in_valid && in_ready;
    end

    // shared multiplier: sample square, then the three quotient products
    always_comb
    begin
        unique case (state_reg)
            S_ACC:
            begin
                mul_a = MUL_W'(xmag);
                mul_b = MUL_W'(xmag);
            end
            S_P0:
            begin
                mul_a = q_reg[HALF_W-1:0];
                mul_b = q_reg[HALF_W-1:0];
            end
            S_P1:
            begin
                mul_a = q_reg[QUO_W-1:HALF_W];
                mul_b = q_reg[HALF_W-1:0];
            end
            S_P2:
            begin
                mul_a = q_reg[QUO_W-1:HALF_W];
                mul_b = q_reg[QUO_W-1:HALF_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // divider operand: scaled sum magnitude, then scaled square sum
    always_comb
    begin
        if (state_reg == S_MSTART)
            div_dividend = DIVD_W'({smag, {FRAC_BITS{1'b0}}});
        else
            div_dividend = {running_square_sum_reg, {FRAC_BITS{1'b0}}};
    end

    gmv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_len),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // variance: floor(sumsq*256/n) minus floor(q*q/256), clamped at zero
    always_comb
    begin
        msq      = msq_acc_reg[MSQ_ACC_W-1:FRAC_BITS];
        ex2_ext  = MSQ_W'(div_quotient);
        var_full = (ex2_ext > msq) ? (ex2_ext - msq) : '0;
    end

    // sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                if (cnt_inc >= eff_len)
                    state_next = S_MSTART;
                else
                    state_next = S_IDLE;
            end
            S_MSTART:
            begin
                div_start  = 1'b1;
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                if (div_stat.done)
                    state_next = S_P0;
            end
            S_P0:
                state_next = S_P1;
            S_P1:
                state_next = S_P2;
            S_P2:
                state_next = S_VSTART;
            S_VSTART:
            begin
                div_start  = 1'b1;
                state_next = S_VDIV;
            end
            S_VDIV:
            begin
                if (div_stat.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_length_reg <= LEN_W'(1);
            group_count_reg  <= CNT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GROUP_LENGTH: group_length_reg <= cfg_data[LEN_W-1:0];
                REG_GROUP_COUNT:  group_count_reg  <= cfg_data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // accumulators, counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg        <= '0;
            running_square_sum_reg <= '0;
            samples_in_group_reg   <= '0;
            groups_done_reg        <= '0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            // a taken result clears valid unless the output step reloads it
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            if (state_reg == S_ACC)
            begin
                running_sum_reg        <= running_sum_reg + SUM_W'(sample_reg);
                running_square_sum_reg <= running_square_sum_reg + SQSUM_W'(prod);
                samples_in_group_reg   <= cnt_inc;
            end
            else if (state_reg == S_OUT && out_free)
            begin
                running_sum_reg        <= '0;
                running_square_sum_reg <= '0;
                samples_in_group_reg   <= '0;
                groups_done_reg        <= group_last ? '0 : groups_inc;
                out_valid_reg          <= 1'b1;
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            sample_reg <= sample;
        if (state_reg == S_MDIV && div_stat.done)
            q_reg <= div_quotient[QUO_W-1:0];
        unique case (state_reg)
            S_P0: msq_acc_reg <= MSQ_ACC_W'(prod);
            S_P1: msq_acc_reg <= msq_acc_reg + MSQ_ACC_W'({prod, {(HALF_W + 1){1'b0}}});
            S_P2: msq_acc_reg <= msq_acc_reg + MSQ_ACC_W'({prod, {QUO_W{1'b0}}});
            default: ;
        endcase
        if (state_reg == S_OUT && out_free)
        begin
            mean_reg <= sneg ? MEAN_W'(-q_reg[MEAN_W-1:0]) : q_reg[MEAN_W-1:0];
            var_reg  <= var_full[VAR_W-1:0];
            last_reg <= group_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign mean_q8     = mean_reg;
    assign variance_q8 = var_reg;
    assign last_group  = last_reg;

`ifndef SYNTHESIS
    // an accepted sample is accumulated in the next cycle
    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> state_reg == S_ACC)
        else $error("accepted sample not accumulated");

    // divider results are only expected while the sequencer waits for them
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_MDIV || state_reg == S_VDIV))
        else $error("divider finished outside a division state");

    // a division is only started on an idle divider
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("division started on a busy divider");

    // a new result appears only from the output step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // the group counter never runs past the longest group
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        samples_in_group_reg <= LEN_MAX)
        else $error("sample count exceeds the longest group");
`endif

endmodule

`default_nettype wire
